// ----- src/ps2mt_pkg.sv -----
// shared types and constants of the ps2 mouse packet tracker
// no dependencies; every other file refers to it by scoped names
package ps2mt_pkg;

  localparam int CoordBits = 12;
  localparam int SizeBits  = 13;
  localparam int IvalBits  = 32;
  localparam int RadBits   = 7;
  localparam int TsBits    = 64;
  localparam int CfgBits   = 32;

  // screen size, move check interval and click radius reset values
  localparam logic [SizeBits-1:0] ResetWidth    = SizeBits'(640);
  localparam logic [SizeBits-1:0] ResetHeight   = SizeBits'(480);
  localparam logic [IvalBits-1:0] ResetInterval = IvalBits'(32'h0400_0000);
  localparam logic [RadBits-1:0]  ResetRadius   = RadBits'(4);

  // status byte bits
  localparam logic [7:0] OvfMask    = 8'hC0;
  localparam int         SyncBit    = 3;
  localparam int         LeftBit    = 0;
  localparam int         RightBit   = 1;
  localparam int         XSignBit   = 4;
  localparam int         YSignBit   = 5;

  localparam int MaxEvents = 3;

  typedef enum logic [2:0] {
    EvMove      = 3'd0,
    EvLeftDown  = 3'd1,
    EvLeftUp    = 3'd2,
    EvClick     = 3'd3,
    EvDragStart = 3'd4,
    EvDragEnd   = 3'd5
  } evt_kind_e;

  typedef enum logic [1:0] {
    CfgScreenWidth  = 2'd0,
    CfgScreenHeight = 2'd1,
    CfgMoveInterval = 2'd2,
    CfgClickRadius  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SizeBits-1:0] screen_width;
    logic [SizeBits-1:0] screen_height;
    logic [IvalBits-1:0] move_interval;
    logic [RadBits-1:0]  click_radius;
  } cfg_t;

  typedef struct packed {
    evt_kind_e            kind;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic                 lb;
    logic                 rb;
  } evt_t;

  typedef struct packed {
    logic [1:0]                cnt;
    evt_t [MaxEvents-1:0]      slot;
  } evt_bundle_t;

endpackage

// ----- src/ps2mt_byte_if.sv -----
// request channel carrying one raw mouse byte and its timestamp
// depends on ps2mt_pkg for the timestamp width
interface ps2mt_byte_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  data_byte;
  logic [ps2mt_pkg::TsBits-1:0] timestamp;

  modport source (output valid, output data_byte, output timestamp, input ready);
  modport sink   (input valid, input data_byte, input timestamp, output ready);
endinterface

// ----- src/ps2mt_event_if.sv -----
// request channel carrying one decoded mouse event
// depends on ps2mt_pkg for the coordinate width
interface ps2mt_event_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     event_kind;
  logic [ps2mt_pkg::CoordBits-1:0] pos_x;
  logic [ps2mt_pkg::CoordBits-1:0] pos_y;
  logic                           left_pressed;
  logic                           right_pressed;
  logic                           last;

  modport source (output valid, output event_kind, output pos_x, output pos_y,
                  output left_pressed, output right_pressed, output last, input ready);
  modport sink   (input valid, input event_kind, input pos_x, input pos_y,
                  input left_pressed, input right_pressed, input last, output ready);
endinterface

// ----- src/ps2mt_decoder.sv -----
// byte window, cursor and button state; decodes one byte into up to three events
// depends on ps2mt_pkg
module ps2mt_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              commit_i,
  input  logic [7:0]                        data_i,
  input  logic [ps2mt_pkg::TsBits-1:0]      ts_i,
  input  ps2mt_pkg::cfg_t                   cfg_i,
  output ps2mt_pkg::evt_bundle_t            bundle_o
);

  localparam int CB     = ps2mt_pkg::CoordBits;
  localparam int SumW   = CB + 2;
  localparam int ClampW = ((SumW > ps2mt_pkg::SizeBits) ? SumW : ps2mt_pkg::SizeBits) + 1;
  localparam int BoxW   = CB + 3;
  localparam int MaxCoord = (2 ** CB) - 1;

  function automatic logic [CB-1:0] clamp_axis(
    input logic signed [SumW-1:0]          v,
    input logic [ps2mt_pkg::SizeBits-1:0]  size
  );
    logic signed [ClampW-1:0] s;
    logic signed [ClampW-1:0] lim;
    logic signed [ClampW-1:0] maxc;
    s    = ClampW'(v);
    maxc = signed'(ClampW'(MaxCoord));
    if (size == '0) begin
      lim = '0;
    end else begin
      lim = signed'(ClampW'(size)) - signed'(ClampW'(1));
    end
    if (lim > maxc) lim = maxc;
    if (s > lim) s = lim;
    if (s < signed'(ClampW'(0))) s = '0;
    return s[CB-1:0];
  endfunction

  function automatic logic in_box(
    input logic [CB-1:0]                  cx,
    input logic [CB-1:0]                  px,
    input logic [ps2mt_pkg::RadBits-1:0]  r
  );
    logic signed [BoxW-1:0] d;
    logic signed [BoxW-1:0] span;
    d    = signed'(BoxW'(cx)) - signed'(BoxW'(px)) + signed'(BoxW'(r));
    span = signed'(BoxW'({r, 1'b0}));
    return (d >= signed'(BoxW'(0))) && (d < span);
  endfunction

  logic [7:0]    older_q, newer_q;
  logic [1:0]    held_q;
  logic [CB-1:0] cur_x_q, cur_y_q, rep_x_q, rep_y_q, press_x_q, press_y_q;
  logic [CB-1:0] cur_x_d, cur_y_d, rep_x_d, rep_y_d, press_x_d, press_y_d;
  logic          left_q, left_d, drag_q, drag_d;
  logic [ps2mt_pkg::TsBits-1:0] lct_q, lct_d;

  logic                   bad_status, good_pkt;
  logic signed [SumW-1:0] dx, dy;
  logic                   lb, rb, ldown, box_hit;
  logic [CB-1:0]          box_px, box_py;
  logic [ps2mt_pkg::TsBits-1:0] gap;
  logic                   gap_due;
  logic [1:0]             n;
  ps2mt_pkg::evt_bundle_t bun;

  always_comb begin
    bad_status = ((older_q & ps2mt_pkg::OvfMask) != 8'h00) || !older_q[ps2mt_pkg::SyncBit];
    good_pkt   = (held_q == 2'd2) && !bad_status;
    dx = SumW'(signed'({older_q[ps2mt_pkg::XSignBit], newer_q}));
    // screen y grows downward
    dy = -SumW'(signed'({older_q[ps2mt_pkg::YSignBit], data_i}));
    cur_x_d = clamp_axis(signed'(SumW'(cur_x_q)) + dx, cfg_i.screen_width);
    cur_y_d = clamp_axis(signed'(SumW'(cur_y_q)) + dy, cfg_i.screen_height);
    lb = older_q[ps2mt_pkg::LeftBit];
    rb = older_q[ps2mt_pkg::RightBit];
    ldown = lb && !left_q;
    // a fresh press puts the press point at the new cursor
    box_px  = ldown ? cur_x_d : press_x_q;
    box_py  = ldown ? cur_y_d : press_y_q;
    box_hit = in_box(cur_x_d, box_px, cfg_i.click_radius) &&
              in_box(cur_y_d, box_py, cfg_i.click_radius);
    gap     = ts_i - lct_q;
    gap_due = gap > ps2mt_pkg::TsBits'(cfg_i.move_interval);
  end

  always_comb begin
    bun       = '0;
    n         = 2'd0;
    left_d    = left_q;
    drag_d    = drag_q;
    press_x_d = press_x_q;
    press_y_d = press_y_q;
    rep_x_d   = rep_x_q;
    rep_y_d   = rep_y_q;
    lct_d     = lct_q;
    for (int i = 0; i < ps2mt_pkg::MaxEvents; i++) begin
      bun.slot[i].lb = lb;
      bun.slot[i].rb = rb;
      bun.slot[i].x  = cur_x_d;
      bun.slot[i].y  = cur_y_d;
    end
    if (lb) begin
      if (!left_q) begin
        bun.slot[n].kind = ps2mt_pkg::EvLeftDown;
        n         = n + 2'd1;
        left_d    = 1'b1;
        press_x_d = cur_x_d;
        press_y_d = cur_y_d;
      end
    end else begin
      if (drag_q) begin
        drag_d = 1'b0;
        bun.slot[n].kind = ps2mt_pkg::EvDragEnd;
        n = n + 2'd1;
      end
      if (left_q) begin
        left_d = 1'b0;
        bun.slot[n].kind = ps2mt_pkg::EvLeftUp;
        n = n + 2'd1;
        if (box_hit) begin
          bun.slot[n].kind = ps2mt_pkg::EvClick;
          bun.slot[n].x    = press_x_q;
          bun.slot[n].y    = press_y_q;
          n = n + 2'd1;
        end
      end
    end
    // a full set of release events skips the move check altogether
    if (n != 2'd3 && gap_due) begin
      lct_d = ts_i;
      if (rep_x_q != cur_x_d || rep_y_q != cur_y_d) begin
        bun.slot[n].kind = ps2mt_pkg::EvMove;
        n       = n + 2'd1;
        rep_x_d = cur_x_d;
        rep_y_d = cur_y_d;
        if (left_d && !drag_d) begin
          drag_d = 1'b1;
          if (!box_hit && n != 2'd3) begin
            bun.slot[n].kind = ps2mt_pkg::EvDragStart;
            n = n + 2'd1;
          end
        end
      end
    end
    bun.cnt = good_pkt ? n : 2'd0;
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q   <= '0;
      newer_q   <= '0;
      held_q    <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      rep_x_q   <= '0;
      rep_y_q   <= '0;
      press_x_q <= '0;
      press_y_q <= '0;
      left_q    <= 1'b0;
      drag_q    <= 1'b0;
      lct_q     <= '0;
    end else if (commit_i) begin
      if (good_pkt) begin
        held_q    <= 2'd0;
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        rep_x_q   <= rep_x_d;
        rep_y_q   <= rep_y_d;
        press_x_q <= press_x_d;
        press_y_q <= press_y_d;
        left_q    <= left_d;
        drag_q    <= drag_d;
        lct_q     <= lct_d;
      end else begin
        // a bad status byte, or a window not yet full, slides the window by one byte
        older_q <= newer_q;
        newer_q <= data_i;
        if (held_q != 2'd2) held_q <= held_q + 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q != 2'd3)
    else $error("byte window count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) drag_q |-> left_q)
    else $error("drag active without left button held");

endmodule

// ----- src/ps2mt_evt_queue.sv -----
// result register holding the events of one byte, handed out one per cycle while pop_i is high
// depends on ps2mt_pkg
module ps2mt_evt_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ps2mt_pkg::evt_bundle_t bundle_i,
  input  logic                   pop_i,
  output logic                   free_o,
  output logic                   valid_o,
  output ps2mt_pkg::evt_t        evt_o,
  output logic                   last_o
);

  ps2mt_pkg::evt_bundle_t bun_q;
  logic                   bun_v_q;
  logic [1:0]             idx_q;

  assign valid_o = bun_v_q;
  assign evt_o   = bun_q.slot[idx_q];
  assign last_o  = (idx_q == bun_q.cnt - 2'd1);
  assign free_o  = !bun_v_q || (pop_i && last_o);

  always_ff @(posedge clk_i) begin
    if (load_i) bun_q <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_v_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      bun_v_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop_i) begin
      if (last_o) begin
        bun_v_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   bun_v_q |-> (bun_q.cnt != 2'd0 && idx_q < bun_q.cnt))
    else $error("event index beyond held event count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (bun_v_q && !pop_i && !load_i) |=> (bun_v_q && $stable(idx_q)))
    else $error("held event moved without being taken");

endmodule

// ----- src/ps2_mouse_packet_tracker.sv -----
// ps2 mouse packet tracker: bytes in, cursor and button events out
// depends on ps2mt_pkg, ps2mt_byte_if, ps2mt_event_if, ps2mt_decoder, ps2mt_evt_queue
//
// byte_i takes raw mouse bytes with a timestamp; evt_o hands out move, left down,
// left up, click, drag start and drag end events, last marking the final event
// of a byte. cfg_we_i/cfg_idx_i/cfg_wdata_i write screen width, screen height,
// move interval and click radius; write them only while no byte is in flight.
// an accepted byte is decoded straight out of the input register and all its
// events load the result register at the edge where that register is free to
// take them; a byte with no events loads nothing.
// bytes with no events flow one per cycle while the result register is free; a
// byte with events holds the result register until evt_o has handed them all
// out, one event per cycle while evt_o is ready, up to three per byte.
// the input register can take one more byte while events wait at evt_o.
// reset clears the byte window, cursor, button and drag state, the move timer
// and loads the default configuration (640 x 480, interval 0x04000000, radius 4).
// when evt_o stalls the held event stays put and the next byte waits in the
// input register, which back-pressures byte_i.
module ps2_mouse_packet_tracker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ps2mt_byte_if.sink                      byte_i,
  ps2mt_event_if.source                   evt_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [ps2mt_pkg::CfgBits-1:0]   cfg_wdata_i
);

  ps2mt_pkg::cfg_t cfg_q;

  logic                          in_v_q;
  logic [7:0]                    in_data_q;
  logic [ps2mt_pkg::TsBits-1:0]  in_ts_q;

  logic                   commit, load, pop, q_free, q_valid, q_last;
  ps2mt_pkg::evt_bundle_t bundle;
  ps2mt_pkg::evt_t        q_evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= ps2mt_pkg::ResetWidth;
      cfg_q.screen_height <= ps2mt_pkg::ResetHeight;
      cfg_q.move_interval <= ps2mt_pkg::ResetInterval;
      cfg_q.click_radius  <= ps2mt_pkg::ResetRadius;
    end else if (cfg_we_i) begin
      case (ps2mt_pkg::cfg_idx_e'(cfg_idx_i))
        ps2mt_pkg::CfgScreenWidth:
          cfg_q.screen_width <= cfg_wdata_i[ps2mt_pkg::SizeBits-1:0];
        ps2mt_pkg::CfgScreenHeight:
          cfg_q.screen_height <= cfg_wdata_i[ps2mt_pkg::SizeBits-1:0];
        ps2mt_pkg::CfgMoveInterval:
          cfg_q.move_interval <= cfg_wdata_i[ps2mt_pkg::IvalBits-1:0];
        ps2mt_pkg::CfgClickRadius:
          cfg_q.click_radius <= cfg_wdata_i[ps2mt_pkg::RadBits-1:0];
        default: ;
      endcase
    end
  end

  // a byte is decoded once the result register can take its events
  assign commit       = in_v_q && q_free;
  assign load         = commit && (bundle.cnt != 2'd0);
  assign byte_i.ready = !in_v_q || commit;
  assign pop          = q_valid && evt_o.ready;

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_data_q <= byte_i.data_byte;
      in_ts_q   <= byte_i.timestamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_v_q <= 1'b1;
    end else if (commit) begin
      in_v_q <= 1'b0;
    end
  end

  ps2mt_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .data_i   (in_data_q),
    .ts_i     (in_ts_q),
    .cfg_i    (cfg_q),
    .bundle_o (bundle)
  );

  ps2mt_evt_queue u_evt_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .pop_i    (pop),
    .free_o   (q_free),
    .valid_o  (q_valid),
    .evt_o    (q_evt),
    .last_o   (q_last)
  );

  assign evt_o.valid         = q_valid;
  assign evt_o.event_kind    = q_evt.kind;
  assign evt_o.pos_x         = q_evt.x;
  assign evt_o.pos_y         = q_evt.y;
  assign evt_o.left_pressed  = q_evt.lb;
  assign evt_o.right_pressed = q_evt.rb;
  assign evt_o.last          = q_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_v_q && !commit) |=> (in_v_q && $stable(in_ts_q) && $stable(in_data_q)))
    else $error("waiting byte lost from the input register");

endmodule

// ----- tb/ps2_mouse_packet_tracker_tb.sv -----
// testbench for ps2_mouse_packet_tracker: raw mouse bytes go in, decoded events are checked
// against an in-bench decoder of the three-byte packet protocol
// depends on ps2mt_pkg, ps2mt_byte_if, ps2mt_event_if and the tracker itself
module ps2_mouse_packet_tracker_tb;

  typedef struct {
    logic [7:0]                   data;
    logic [ps2mt_pkg::TsBits-1:0] ts;
    bit                           drain;
  } mouse_byte_t;

  typedef struct {
    ps2mt_pkg::evt_kind_e            kind;
    logic [ps2mt_pkg::CoordBits-1:0] x;
    logic [ps2mt_pkg::CoordBits-1:0] y;
    logic                            lb;
    logic                            rb;
    logic                            last_evt;
  } mouse_evt_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_idx_i = ps2mt_pkg::CfgScreenWidth;
  logic [ps2mt_pkg::CfgBits-1:0] cfg_wdata_i = '0;

  ps2mt_byte_if  byte_if ();
  ps2mt_event_if evt_if ();

  ps2_mouse_packet_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_if),
    .evt_o       (evt_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // request queues: bytes still to send, events the decoder has predicted
  mouse_byte_t byte_backlog[$];
  mouse_evt_t  event_forecast[$];
  mouse_byte_t next_byte;
  mouse_evt_t  want_evt;

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          byte_taken;
  int          n_fail = 0;
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_events = 0;
  int          n_cfg = 0;

  // stimulus timestamp generation
  logic [ps2mt_pkg::TsBits-1:0] ts_now = '0;
  logic [31:0]                  ts_step = 32'h0500_0000;
  bit                           ts_rand = 1'b0;
  bit                           gen_left = 1'b0;
  int                           pkt_count = 0;

  // decoder state and its copy of the registers
  logic [7:0]                     win [3];
  int unsigned                    wr_slot = 0;
  int unsigned                    n_held = 0;
  int                             cur_x = 0, cur_y = 0;
  int                             rep_x = 0, rep_y = 0;
  int                             prs_x = 0, prs_y = 0;
  bit                             left_down_q = 1'b0;
  bit                             drag_q = 1'b0;
  logic [ps2mt_pkg::TsBits-1:0]   chk_time = '0;
  logic [ps2mt_pkg::SizeBits-1:0] cfg_w = ps2mt_pkg::ResetWidth;
  logic [ps2mt_pkg::SizeBits-1:0] cfg_h = ps2mt_pkg::ResetHeight;
  logic [ps2mt_pkg::IvalBits-1:0] cfg_ival = ps2mt_pkg::ResetInterval;
  logic [ps2mt_pkg::RadBits-1:0]  cfg_rad = ps2mt_pkg::ResetRadius;

  initial begin
    win[0] = '0;
    win[1] = '0;
    win[2] = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.timestamp = '0;
    evt_if.ready = 1'b0;
  end

  function automatic int clamp_coord(int v, logic [ps2mt_pkg::SizeBits-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > (1 << ps2mt_pkg::CoordBits) - 1) lim = (1 << ps2mt_pkg::CoordBits) - 1;
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return v;
  endfunction

  // release point within the box of half size radius around the press point
  function automatic bit near_press();
    int r, ox, oy;
    r = int'(cfg_rad);
    ox = cur_x - prs_x + r;
    oy = cur_y - prs_y + r;
    return ox >= 0 && ox < 2 * r && oy >= 0 && oy < 2 * r;
  endfunction

  function automatic mouse_evt_t mk_evt(ps2mt_pkg::evt_kind_e kind, int x, int y,
                                        logic lb, logic rb);
    mouse_evt_t e;
    e.kind = kind;
    e.x = ps2mt_pkg::CoordBits'(x);
    e.y = ps2mt_pkg::CoordBits'(y);
    e.lb = lb;
    e.rb = rb;
    e.last_evt = 1'b0;
    return e;
  endfunction

  // slides the byte window and decodes a packet once three bytes line up
  function automatic void decode_mouse_byte(logic [7:0] d, logic [ps2mt_pkg::TsBits-1:0] ts);
    logic [7:0] s0, s1, s2;
    logic       lb, rb;
    int         mx, my;
    mouse_evt_t batch[$];
    win[wr_slot] = d;
    wr_slot = (wr_slot + 1) % 3;
    if (n_held < 3) n_held++;
    if (n_held < 3) return;
    s0 = win[wr_slot];
    s1 = win[(wr_slot + 1) % 3];
    s2 = d;
    if ((s0 & ps2mt_pkg::OvfMask) != 0 || !s0[ps2mt_pkg::SyncBit]) begin
      n_held = 2;
      return;
    end
    mx = int'(s1) - (s0[ps2mt_pkg::XSignBit] ? 256 : 0);
    // screen y grows downward
    my = (s0[ps2mt_pkg::YSignBit] ? 256 : 0) - int'(s2);
    cur_x = clamp_coord(cur_x + mx, cfg_w);
    cur_y = clamp_coord(cur_y + my, cfg_h);
    lb = s0[ps2mt_pkg::LeftBit];
    rb = s0[ps2mt_pkg::RightBit];
    if (lb) begin
      if (!left_down_q) begin
        batch.push_back(mk_evt(ps2mt_pkg::EvLeftDown, cur_x, cur_y, lb, rb));
        left_down_q = 1'b1;
        prs_x = cur_x;
        prs_y = cur_y;
      end
    end else begin
      if (drag_q) begin
        drag_q = 1'b0;
        batch.push_back(mk_evt(ps2mt_pkg::EvDragEnd, cur_x, cur_y, lb, rb));
      end
      if (left_down_q) begin
        left_down_q = 1'b0;
        batch.push_back(mk_evt(ps2mt_pkg::EvLeftUp, cur_x, cur_y, lb, rb));
        if (near_press()) batch.push_back(mk_evt(ps2mt_pkg::EvClick, prs_x, prs_y, lb, rb));
      end
    end
    // a full set of button events pushes the move check to a later packet
    if (batch.size() < ps2mt_pkg::MaxEvents &&
        (ts - chk_time) > ps2mt_pkg::TsBits'(cfg_ival)) begin
      chk_time = ts;
      if (rep_x != cur_x || rep_y != cur_y) begin
        batch.push_back(mk_evt(ps2mt_pkg::EvMove, cur_x, cur_y, lb, rb));
        rep_x = cur_x;
        rep_y = cur_y;
        if (left_down_q && !drag_q) begin
          drag_q = 1'b1;
          if (!near_press() && batch.size() < ps2mt_pkg::MaxEvents)
            batch.push_back(mk_evt(ps2mt_pkg::EvDragStart, cur_x, cur_y, lb, rb));
        end
      end
    end
    n_held = 0;
    wr_slot = 0;
    if (batch.size() > 0) batch[batch.size() - 1].last_evt = 1'b1;
    foreach (batch[i]) event_forecast.push_back(batch[i]);
  endfunction

  function automatic void check_field(string name, logic [ps2mt_pkg::CoordBits-1:0] want_v,
                                      logic [ps2mt_pkg::CoordBits-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      n_fail++;
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= byte_if.valid && byte_if.ready;
      if (evt_if.valid && evt_if.ready) begin
        n_events++;
        if (event_forecast.size() == 0) begin
          $error("event_kind: expected none, actual %0d at (%0d,%0d)",
                 evt_if.event_kind, evt_if.pos_x, evt_if.pos_y);
          n_fail++;
        end else begin
          want_evt = event_forecast.pop_front();
          check_field("event_kind", ps2mt_pkg::CoordBits'(want_evt.kind),
                      ps2mt_pkg::CoordBits'(evt_if.event_kind));
          check_field("pos_x", want_evt.x, evt_if.pos_x);
          check_field("pos_y", want_evt.y, evt_if.pos_y);
          check_field("left_pressed", ps2mt_pkg::CoordBits'(want_evt.lb),
                      ps2mt_pkg::CoordBits'(evt_if.left_pressed));
          check_field("right_pressed", ps2mt_pkg::CoordBits'(want_evt.rb),
                      ps2mt_pkg::CoordBits'(evt_if.right_pressed));
          check_field("last", ps2mt_pkg::CoordBits'(want_evt.last_evt),
                      ps2mt_pkg::CoordBits'(evt_if.last));
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        decode_mouse_byte(byte_if.data_byte, byte_if.timestamp);
        n_taken++;
      end
    end
  end

  // byte driver: holds a request until taken, may idle between requests
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_taken) begin
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct &&
          !(byte_backlog[0].drain && event_forecast.size() != 0)) begin
        next_byte = byte_backlog.pop_front();
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= next_byte.data;
        byte_if.timestamp <= next_byte.ts;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    evt_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic push_byte(logic [7:0] d, bit drain);
    if (!ts_rand) ts_now += ts_step;
    else if ($urandom_range(0, 9) == 0) ts_now = {$urandom, $urandom};
    else ts_now += $urandom_range(0, ts_step);
    byte_backlog.push_back('{d, ts_now, drain});
    n_queued++;
  endtask

  task automatic push_packet(logic [7:0] st, logic [7:0] bx, logic [7:0] by);
    push_byte(st, 1'b0);
    push_byte(bx, 1'b0);
    push_byte(by, 1'b0);
  endtask

  // mostly well-formed packets, some stray bytes and corrupt status bytes
  task automatic push_random_packet();
    int         sel, v;
    logic [8:0] mx, my;
    logic [7:0] st;
    sel = $urandom_range(0, 99);
    pkt_count++;
    if (sel < 8) begin
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (sel < 16) begin
      st = 8'($urandom_range(0, 255));
      if ((st & ps2mt_pkg::OvfMask) == 0 && st[ps2mt_pkg::SyncBit]) begin
        if ($urandom_range(0, 1)) st[6 + $urandom_range(0, 1)] = 1'b1;
        else st[ps2mt_pkg::SyncBit] = 1'b0;
      end
      push_packet(st, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 9) < 3) gen_left = ~gen_left;
      if ($urandom_range(0, 1)) begin
        v = $urandom_range(0, 8) - 4;
        mx = 9'(v);
      end else begin
        mx = 9'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 1)) begin
        v = $urandom_range(0, 8) - 4;
        my = 9'(v);
      end else begin
        my = 9'($urandom_range(0, 511));
      end
      st = {2'b00, my[8], mx[8], 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            gen_left};
      // now and then hold the next request until all events are out
      push_byte(st, pkt_count % 9 == 4);
      push_byte(mx[7:0], 1'b0);
      push_byte(my[7:0], 1'b0);
    end
  endtask

  task automatic cfg_write(ps2mt_pkg::cfg_idx_e idx, logic [ps2mt_pkg::CfgBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      ps2mt_pkg::CfgScreenWidth:  cfg_w = val[ps2mt_pkg::SizeBits-1:0];
      ps2mt_pkg::CfgScreenHeight: cfg_h = val[ps2mt_pkg::SizeBits-1:0];
      ps2mt_pkg::CfgMoveInterval: cfg_ival = val[ps2mt_pkg::IvalBits-1:0];
      ps2mt_pkg::CfgClickRadius:  cfg_rad = val[ps2mt_pkg::RadBits-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait for every byte to be taken and every event to arrive, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    while ((n_taken != n_queued || event_forecast.size() != 0) && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (n_taken != n_queued) begin
      $error("%0d mouse bytes never taken", n_queued - n_taken);
      n_fail++;
    end
    if (event_forecast.size() != 0) begin
      $error("%0d events still expected after draining", event_forecast.size());
      n_fail++;
    end
  endtask

  task automatic random_phase(logic [ps2mt_pkg::SizeBits-1:0] w,
                              logic [ps2mt_pkg::SizeBits-1:0] h,
                              logic [ps2mt_pkg::IvalBits-1:0] ival,
                              logic [ps2mt_pkg::RadBits-1:0] rad,
                              logic [31:0] step, int src_pct, int snk_pct);
    cfg_write(ps2mt_pkg::CfgScreenWidth, ps2mt_pkg::CfgBits'(w));
    cfg_write(ps2mt_pkg::CfgScreenHeight, ps2mt_pkg::CfgBits'(h));
    cfg_write(ps2mt_pkg::CfgMoveInterval, ps2mt_pkg::CfgBits'(ival));
    cfg_write(ps2mt_pkg::CfgClickRadius, ps2mt_pkg::CfgBits'(rad));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    ts_rand = 1'b1;
    ts_step = step;
    repeat (5) push_random_packet();
    settle();
  endtask

  initial begin
    src_idle_pct = 21;
    snk_idle_pct = 88;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part under the reset configuration, each byte far enough apart for a move check
    // corrupt status bytes until the window lines up on a valid packet
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h08, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h05, 1'b0);
    // press, then a small move that starts a drag inside the click box
    push_packet(8'h09, 8'h00, 8'h00);
    push_packet(8'h09, 8'h02, 8'h00);
    // release with movement: drag end, left up and click fill all slots, move deferred
    push_byte(8'h08, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_packet(8'h08, 8'h00, 8'h00);
    // press with right button, far move reports a drag start
    push_packet(8'h0B, 8'h00, 8'h00);
    push_packet(8'h0B, 8'hFF, 8'h00);
    // release with the most negative x and y deltas, moving the cursor left and down the screen
    push_packet(8'h3A, 8'h00, 8'h00);
    settle();

    random_phase(13'd0, 13'h1FFF, 32'd0, 7'd0, 32'd3, 21, 88);
    random_phase(13'd4096, 13'd1, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF, 21, 88);
    random_phase(13'd100, 13'd80, 32'd50, 7'd1, 32'd40, 88, 21);
    random_phase(13'd33, 13'd17, 32'd20, 7'd64, 32'd15, 88, 21);
    random_phase(13'd640, 13'd480, 32'd200, 7'd4, 32'd100, 0, 0);
    random_phase(13'd13, 13'd9, 32'd7, 7'd3, 32'd5, 0, 0);

    $display("sent %0d mouse bytes and checked %0d events", n_taken, n_events);
    $display("went through %0d register writes across seven configurations", n_cfg);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/ps2mt_pkg.sv
src/ps2mt_byte_if.sv
src/ps2mt_event_if.sv
src/ps2mt_decoder.sv
src/ps2mt_evt_queue.sv
src/ps2_mouse_packet_tracker.sv
tb/ps2_mouse_packet_tracker_tb.sv
